// ----- hw/rtl/clre_pkg.sv -----
// Shared constants and types for the constant-level run extractor.
package clre_pkg;

    localparam int unsigned MAX_POINTS = 65536;
    localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
    localparam int unsigned COORD_W    = 32;
    localparam int unsigned TOL_W      = 31;
    localparam int unsigned MINPT_W    = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Result queue: deep enough for one full burst plus one waiting entry.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;
    localparam int unsigned MAX_BURST  = 3;

    // Candidate results of one point, in emission order.
    localparam int unsigned NUM_CAND   = 5;

    localparam logic [IDX_W-1:0]   LAST_INDEX = IDX_W'(MAX_POINTS - 1);
    localparam logic [MINPT_W-1:0] MIN_RUN    = MINPT_W'(2);

    // Configuration register indices.
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_SELECT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_TIGHT_TOL   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_LOOSE_TOL   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_POINTS  = CFG_IDX_W'(4);

    // Segment kinds.
    localparam logic KIND_PLAIN = 1'b0;
    localparam logic KIND_RUN   = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] last_index;
        logic             segment_kind;
        logic             end_of_burst;
        logic             end_of_set;
    } result_t;

endpackage

// ----- hw/rtl/constant_level_run_extractor_top.sv -----
// Constant-level run extractor: splits a polyline into plain ranges and level runs.
// A point is registered at acceptance (offset from level taken there); it is evaluated once the
//   queue has room for a full burst, and its results are then written into the queue behind any earlier ones.
// Throughput: one point per cycle while each point gives at most one result and the output is
//   ready; a point that gives two or three results holds the input stage while the four-entry
//   queue drains to one.
// Reset (rst_n, asynchronous, active low): queue and input stage empty, no run open,
//   index counter and pending start at zero, registers at axis 0, level 0, tolerances 0,
//   min_points 2.
module constant_level_run_extractor_top
    import clre_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    // configuration write port
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,

    // point input
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [COORD_W-1:0] coord_u,
    input  logic signed [COORD_W-1:0] coord_v,
    input  logic                    final_point,

    // segment output
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [IDX_W-1:0]        first_index,
    output logic [IDX_W-1:0]        last_index,
    output logic                    segment_kind,
    output logic                    end_of_burst,
    output logic                    end_of_set
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                      axis_select_reg;
    logic signed [COORD_W-1:0] level_reg;
    logic [TOL_W-1:0]          tight_tol_reg;
    logic [TOL_W-1:0]          loose_tol_reg;
    logic [MINPT_W-1:0]        min_points_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_select_reg <= 1'b0;
            level_reg       <= '0;
            tight_tol_reg   <= '0;
            loose_tol_reg   <= '0;
            min_points_reg  <= MIN_RUN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_AXIS_SELECT: axis_select_reg <= cfg_data[0];
                CFG_LEVEL:       level_reg       <= cfg_data;
                CFG_TIGHT_TOL:   tight_tol_reg   <= cfg_data[TOL_W-1:0];
                CFG_LOOSE_TOL:   loose_tol_reg   <= cfg_data[TOL_W-1:0];
                CFG_MIN_POINTS:  min_points_reg  <= cfg_data[MINPT_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input stage: select the tested coordinate and take its offset
    // from the level at 33 bits (exact).
    // ------------------------------------------------------------------
    logic                      s1_valid_reg;
    logic signed [COORD_W:0]   s1_diff_reg;
    logic                      s1_fin_reg;
    logic signed [COORD_W:0]   in_diff;
    logic                      s1_adv;

    logic [FIFO_CNT_W-1:0]     fifo_cnt_reg;

    // Room for a full burst is needed before a point is evaluated.
    assign s1_adv   = s1_valid_reg &&
                      (fifo_cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - MAX_BURST));
    assign in_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        if (axis_select_reg)
            in_diff = {coord_v[COORD_W-1], coord_v} - {level_reg[COORD_W-1], level_reg};
        else
            in_diff = {coord_u[COORD_W-1], coord_u} - {level_reg[COORD_W-1], level_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_diff_reg <= in_diff;
            s1_fin_reg  <= final_point;
        end
    end

    // ------------------------------------------------------------------
    // Evaluate stage: tolerance tests and run tracking
    // ------------------------------------------------------------------
    logic             in_run_reg,         in_run_next;
    logic [IDX_W-1:0] point_count_reg,    point_count_next;
    logic [IDX_W-1:0] pending_start_reg,  pending_start_next;
    logic [IDX_W-1:0] run_first_reg,      run_first_next;
    logic [IDX_W-1:0] run_last_tight_reg, run_last_tight_next;

    logic [COORD_W:0] mag;
    logic             tight;
    logic             loose;
    logic [IDX_W:0]   need;
    logic [IDX_W:0]   len1;
    logic [IDX_W:0]   len2;
    logic             close1_ok;
    logic             close2_ok;
    logic [IDX_W-1:0] pend1;
    logic [IDX_W-1:0] pend2;
    logic             run1;
    logic             run2;
    logic [IDX_W-1:0] rf2;
    logic [IDX_W-1:0] rlt2;
    logic [IDX_W-1:0] idx;

    result_t          cand     [NUM_CAND];
    logic             cand_vld [NUM_CAND];
    logic [FIFO_CNT_W-1:0] cand_pos [NUM_CAND];
    logic [FIFO_CNT_W-1:0] push_n;

    always_comb
    begin
        idx   = point_count_reg;
        mag   = s1_diff_reg[COORD_W] ? (COORD_W+1)'(-s1_diff_reg) : (COORD_W+1)'(s1_diff_reg);
        tight = mag <= {2'b00, tight_tol_reg};
        loose = mag <= {2'b00, loose_tol_reg};

        // min_points of 0 or 1 behaves as 2
        need = (min_points_reg < MIN_RUN) ? {1'b0, MIN_RUN} : {1'b0, min_points_reg};

        // A run closes on the first point outside the loose band.
        len1      = {1'b0, run_last_tight_reg} - {1'b0, run_first_reg} + (IDX_W+1)'(1);
        close1_ok = in_run_reg && !loose && (len1 >= need);
        pend1     = close1_ok ? run_last_tight_reg : pending_start_reg;
        run1      = in_run_reg && loose;

        // Extend the open run or open a new one at a tight point.
        rf2  = run_first_reg;
        rlt2 = run_last_tight_reg;
        if (run1)
        begin
            if (tight)
                rlt2 = idx;
        end
        else if (tight)
        begin
            rf2  = idx;
            rlt2 = idx;
        end
        run2 = run1 || tight;

        // Final point closes whatever is still open.
        len2      = {1'b0, rlt2} - {1'b0, rf2} + (IDX_W+1)'(1);
        close2_ok = s1_fin_reg && run2 && (len2 >= need);
        pend2     = close2_ok ? rlt2 : pend1;

        // Candidate results in emission order
        cand[0] = '{first_index: pending_start_reg, last_index: run_first_reg,
                    segment_kind: KIND_PLAIN, end_of_burst: 1'b0, end_of_set: 1'b0};
        cand[1] = '{first_index: run_first_reg, last_index: run_last_tight_reg,
                    segment_kind: KIND_RUN, end_of_burst: 1'b0, end_of_set: 1'b0};
        cand[2] = '{first_index: pend1, last_index: rf2,
                    segment_kind: KIND_PLAIN, end_of_burst: 1'b0, end_of_set: 1'b0};
        cand[3] = '{first_index: rf2, last_index: rlt2,
                    segment_kind: KIND_RUN, end_of_burst: 1'b0, end_of_set: 1'b0};
        cand[4] = '{first_index: pend2, last_index: idx,
                    segment_kind: KIND_PLAIN, end_of_burst: 1'b0, end_of_set: 1'b0};

        cand_vld[0] = close1_ok && (run_first_reg > pending_start_reg);
        cand_vld[1] = close1_ok;
        cand_vld[2] = close2_ok && (rf2 > pend1);
        cand_vld[3] = close2_ok;
        cand_vld[4] = s1_fin_reg && (pend2 < idx);

        // Queue slot of each candidate, and burst/set marks on the last one
        push_n = '0;
        for (int k = 0; k < NUM_CAND; k++)
        begin
            cand_pos[k] = push_n;
            push_n      = push_n + FIFO_CNT_W'(cand_vld[k]);
        end
        for (int k = 0; k < NUM_CAND; k++)
        begin
            if (cand_pos[k] == push_n - FIFO_CNT_W'(1))
            begin
                cand[k].end_of_burst = 1'b1;
                cand[k].end_of_set   = s1_fin_reg;
            end
        end

        // State update
        if (s1_fin_reg)
        begin
            in_run_next        = 1'b0;
            point_count_next   = '0;
            pending_start_next = '0;
        end
        else
        begin
            in_run_next        = run2;
            point_count_next   = (idx < LAST_INDEX) ? idx + IDX_W'(1) : idx;
            pending_start_next = pend1;
        end
        run_first_next      = rf2;
        run_last_tight_next = rlt2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg         <= 1'b0;
            point_count_reg    <= '0;
            pending_start_reg  <= '0;
            run_first_reg      <= '0;
            run_last_tight_reg <= '0;
        end
        else if (s1_adv)
        begin
            in_run_reg         <= in_run_next;
            point_count_reg    <= point_count_next;
            pending_start_reg  <= pending_start_next;
            run_first_reg      <= run_first_next;
            run_last_tight_reg <= run_last_tight_next;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: up to three writes per cycle, one read per cycle.
    // ------------------------------------------------------------------
    result_t               fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] push_cnt;
    logic                  pop;
    result_t               head;

    assign push_cnt = s1_adv ? push_n : '0;
    assign pop      = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_reg + push_cnt[FIFO_PTR_W-1:0];
            rd_ptr_reg   <= rd_ptr_reg + FIFO_PTR_W'(pop);
            fifo_cnt_reg <= fifo_cnt_reg + push_cnt - FIFO_CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_CAND; k++)
        begin
            if (s1_adv && cand_vld[k])
                fifo_mem[wr_ptr_reg + cand_pos[k][FIFO_PTR_W-1:0]] <= cand[k];
        end
    end

    assign head         = fifo_mem[rd_ptr_reg];
    assign out_valid    = (fifo_cnt_reg != '0);
    assign first_index  = head.first_index;
    assign last_index   = head.last_index;
    assign segment_kind = head.segment_kind;
    assign end_of_burst = head.end_of_burst;
    assign end_of_set   = head.end_of_set;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |-> push_n <= FIFO_CNT_W'(MAX_BURST))
        else $error("more than three results for one point");

    a_set_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_set |-> end_of_burst)
        else $error("end_of_set without end_of_burst");

    a_fin_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_fin_reg |=> (point_count_reg == '0) && !in_run_reg)
        else $error("polyline state not cleared after final point");

endmodule
